@@ rtl/rlf_pkg.sv @@
// Shared types and constants for the RGBA linear fade engine.
package rlf_pkg;

   localparam int NUM_CHAN = 4;
   localparam int CHAN_W = 8;
   localparam int CHAN_IDX_W = $clog2(NUM_CHAN);
   localparam int STEP_W = 10;
   localparam int DIV_BITS = CHAN_W;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam logic [CHAN_W-1:0] MAX_FADE_STEPS = 8'd254;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_ITER  = 6'b000100,
      ST_WRITE = 6'b001000,
      ST_TICK  = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   typedef struct packed {
      logic                  accept_set;
      logic                  div_load;
      logic                  div_step;
      logic                  step_wr;
      logic                  tick;
      logic                  finish;
      logic [CHAN_IDX_W-1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic out_stall;
   } status_type;

endpackage

@@ rtl/rlf_ctrl.sv @@
// Sequencer for load, divide, step write, tick and result hand-off.
module rlf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_op,
   input  rlf_pkg::status_type  status,
   output rlf_pkg::cmd_type     cmd
);
   import rlf_pkg::*;

   state_type             state_ff, state_in;
   logic [CHAN_IDX_W-1:0] chan_ff, chan_in;
   logic [DIV_CNT_W-1:0]  bit_ff, bit_in;
   logic                  accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      chan_in = chan_ff;
      bit_in = bit_ff;
      cmd = '0;
      cmd.chan = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_SET) begin
                  cmd.accept_set = 1'b1;
                  chan_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_TICK;
               end
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            bit_in = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.div_step = 1'b1;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.step_wr = 1'b1;
            if (chan_ff == CHAN_IDX_W'(NUM_CHAN - 1)) begin
               state_in = ST_FIN;
            end else begin
               chan_in = chan_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!status.out_stall) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff <= '0;
         bit_ff <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff <= chan_in;
         bit_ff <= bit_in;
      end
   end

endmodule

@@ rtl/rlf_dpath.sv @@
// Color state, shared restoring divider, tick adders and output register.
module rlf_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  rlf_pkg::cmd_type                 cmd,
   output rlf_pkg::status_type              status,
   input  logic [rlf_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rlf_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rlf_pkg::*;

   logic [CHAN_W-1:0]        cur_ff [NUM_CHAN];
   logic [CHAN_W-1:0]        cur_in [NUM_CHAN];
   logic [CHAN_W-1:0]        tgt_ff [NUM_CHAN];
   logic [CHAN_W-1:0]        tgt_in [NUM_CHAN];
   logic [STEP_W-1:0]        step_ff [NUM_CHAN];
   logic [STEP_W-1:0]        step_in [NUM_CHAN];
   logic                     armed_ff, armed_in;
   logic [CHAN_W-1:0]        divisor_ff, divisor_in;
   logic [CHAN_W-1:0]        rem_ff, rem_in;
   logic [CHAN_W-1:0]        quo_ff, quo_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [CHAN_W-1:0]        fade_steps;
   logic [CHAN_W-1:0]        fade_sat;
   logic [CHAN_W:0]          diff;
   logic                     diff_neg;
   logic                     diff_pos;
   logic [CHAN_W-1:0]        mag;
   logic [CHAN_W+1:0]        trial;
   logic [CHAN_W:0]          shifted;
   logic [STEP_W-1:0]        new_step;
   logic signed [CHAN_W+2:0] tick_sum [NUM_CHAN];
   logic signed [CHAN_W+2:0] tick_tgt [NUM_CHAN];
   logic                     equal;

   assign fade_steps = req_tdata[NUM_CHAN*CHAN_W +: CHAN_W];
   assign fade_sat = (fade_steps > MAX_FADE_STEPS) ? MAX_FADE_STEPS : fade_steps;

   assign diff = {1'b0, tgt_ff[cmd.chan]} - {1'b0, cur_ff[cmd.chan]};
   assign diff_neg = diff[CHAN_W];
   assign diff_pos = !diff_neg && (diff != '0);
   assign mag = diff_neg ? CHAN_W'(-diff) : diff[CHAN_W-1:0];

   assign shifted = {rem_ff, quo_ff[CHAN_W-1]};
   assign trial = {1'b0, shifted} - {2'b00, divisor_ff};
   assign new_step = diff_pos ? ({2'b00, quo_ff} + 1'b1) : ~{2'b00, quo_ff};

   always_comb begin
      equal = 1'b1;
      for (int i = 0; i < NUM_CHAN; i++) begin
         if (cur_ff[i] != tgt_ff[i]) begin
            equal = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         cur_in[i] = cur_ff[i];
         tgt_in[i] = tgt_ff[i];
         step_in[i] = step_ff[i];
         tick_sum[i] = $signed({3'b000, cur_ff[i]}) + $signed({step_ff[i][STEP_W-1], step_ff[i]});
         tick_tgt[i] = $signed({3'b000, tgt_ff[i]});
      end
      armed_in = armed_ff;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      if (cmd.accept_set) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            tgt_in[i] = req_tdata[i*CHAN_W +: CHAN_W];
         end
         divisor_in = fade_sat + 1'b1;
         armed_in = 1'b1;
      end

      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = mag;
      end

      if (cmd.div_step) begin
         if (!trial[CHAN_W+1]) begin
            rem_in = trial[CHAN_W-1:0];
            quo_in = {quo_ff[CHAN_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[CHAN_W-1:0];
            quo_in = {quo_ff[CHAN_W-2:0], 1'b0};
         end
      end

      if (cmd.step_wr) begin
         step_in[cmd.chan] = new_step;
      end

      if (cmd.tick) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            if ((!step_ff[i][STEP_W-1] && (step_ff[i] != '0) && (tick_sum[i] >= tick_tgt[i]))
                || (step_ff[i][STEP_W-1] && (tick_sum[i] <= tick_tgt[i]))) begin
               cur_in[i] = tgt_ff[i];
               step_in[i] = '0;
            end else begin
               cur_in[i] = tick_sum[i][CHAN_W-1:0];
            end
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = '0;
         for (int i = 0; i < NUM_CHAN; i++) begin
            rsp_data_in[i*CHAN_W +: CHAN_W] = cur_ff[i];
         end
         rsp_data_in[NUM_CHAN*CHAN_W] = armed_ff && !equal;
         rsp_data_in[NUM_CHAN*CHAN_W+1] = armed_ff && equal;
         if (armed_ff && equal) begin
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            cur_ff[i] <= '0;
            tgt_ff[i] <= '0;
            step_ff[i] <= '0;
         end
         armed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            cur_ff[i] <= cur_in[i];
            tgt_ff[i] <= tgt_in[i];
            step_ff[i] <= step_in[i];
         end
         armed_ff <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.out_stall = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

@@ rtl/rgba_linear_fader.sv @@
// Top level of the four-channel RGBA linear fade engine.
// A tick word passes through the tick and finish states from acceptance to the result word on rsp.
// A set word runs one shared restoring divider for each channel in turn: load, iterate, step write.
// One word is in work at a time; the next is taken once the result is registered.
// Synchronous reset clears the colors, targets, steps, arm and the output valid.
module rgba_linear_fader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // target_red, target_green, target_blue, target_alpha, fade_steps
   input  logic        req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // red, green, blue, alpha, busy_res, done_res, zero fill
);
   import rlf_pkg::*;

   cmd_type    cmd;
   status_type status;

   rlf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   rlf_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/rlf_checker.sv @@
// Port-level checks for the RGBA linear fade engine, bound to its top level.
module rlf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result word changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[33]))
      else $error("Busy and done both set.");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second word accepted while one is in work.");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("Waiting request word changed.");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

endmodule

bind rgba_linear_fader rlf_checker u_rlf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
